@@ src/coap_pkg.sv @@
package coap_pkg;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_END    = 2'd2,
        KIND_ERROR  = 2'd3
    } result_kind_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_list;
    } coap_in_t;

    typedef struct packed {
        result_kind_t result_kind;
        logic [16:0]  option_delta;
        logic [16:0]  option_length;
        logic [7:0]   value_byte;
        logic         last_value;
    } coap_out_t;

    localparam logic [7:0]  END_MARKER    = 8'hFF;
    localparam logic [3:0]  CODE_EXT1     = 4'd13;
    localparam logic [3:0]  CODE_EXT2     = 4'd14;
    localparam logic [3:0]  CODE_RESERVED = 4'd15;
    localparam logic [16:0] BIAS_EXT1     = 17'd13;
    localparam logic [16:0] BIAS_EXT2     = 17'd269;

endpackage

@@ src/coap_option_list_parser_top.sv @@
// CoAP option list parser. Takes one byte of an options area per input
// transaction and decodes option headers (delta nibble high, length nibble low;
// code 13 adds one extension byte plus 13, code 14 adds two big-endian bytes
// plus 269, delta extension first). A completed header gives one header
// result, then every value byte gives one value result with last_value set on
// the final one. A header byte of 0xFF gives an end result, a reserved nibble
// gives an error result, and after either the parser drops bytes until a byte
// flagged start_of_list. Only a header-completing extension byte gives a result.
// Each byte is decoded in the cycle it is accepted and its result lands in the
// output register the next cycle; one byte per cycle is sustained, with s_ready
// low only while the output register holds a result that m_ready has not taken.
module coap_option_list_parser_top
    import coap_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  coap_in_t  s_payload,
    output logic      m_valid,
    input  logic      m_ready,
    output coap_out_t m_payload
);

    typedef enum logic [6:0] {
        PH_HEADER = 7'b0000001,
        PH_DELTA1 = 7'b0000010,
        PH_DELTA2 = 7'b0000100,
        PH_LEN1   = 7'b0001000,
        PH_LEN2   = 7'b0010000,
        PH_VALUE  = 7'b0100000,
        PH_IDLE   = 7'b1000000
    } phase_t;

    phase_t      phase_reg, phase_next, phase_cur;
    logic [3:0]  delta_code_reg, delta_code_next;
    logic [3:0]  length_code_reg, length_code_next;
    logic [16:0] delta_accum_reg, delta_accum_next;
    logic [16:0] length_accum_reg, length_accum_next;
    logic [16:0] value_remaining_reg, value_remaining_next;

    logic        m_valid_reg;
    coap_out_t   m_payload_reg;

    coap_out_t   res;
    logic        res_valid;
    logic        accept;
    logic        after_delta;
    logic        finish_header;
    logic [7:0]  b;
    logic [3:0]  dcode, lcode;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    assign b     = s_payload.data_byte;
    assign dcode = b[7:4];
    assign lcode = b[3:0];

    always_comb begin
        phase_cur            = s_payload.start_of_list ? PH_HEADER : phase_reg;
        phase_next           = phase_cur;
        delta_code_next      = delta_code_reg;
        length_code_next     = length_code_reg;
        delta_accum_next     = delta_accum_reg;
        length_accum_next    = length_accum_reg;
        value_remaining_next = value_remaining_reg;
        res                  = '0;
        res_valid            = 1'b0;
        after_delta          = 1'b0;
        finish_header        = 1'b0;

        unique case (phase_cur)
            PH_HEADER: begin
                if (b == END_MARKER) begin
                    phase_next      = PH_IDLE;
                    res.result_kind = KIND_END;
                    res_valid       = 1'b1;
                end else if (dcode == CODE_RESERVED || lcode == CODE_RESERVED) begin
                    phase_next      = PH_IDLE;
                    res.result_kind = KIND_ERROR;
                    res_valid       = 1'b1;
                end else begin
                    delta_code_next   = dcode;
                    length_code_next  = lcode;
                    delta_accum_next  = {13'd0, dcode};
                    length_accum_next = {13'd0, lcode};
                    if (dcode == CODE_EXT1 || dcode == CODE_EXT2) begin
                        phase_next = PH_DELTA1;
                    end else begin
                        after_delta = 1'b1;
                    end
                end
            end
            PH_DELTA1: begin
                if (delta_code_reg == CODE_EXT1) begin
                    delta_accum_next = {9'd0, b} + BIAS_EXT1;
                    after_delta      = 1'b1;
                end else begin
                    delta_accum_next = {1'b0, b, 8'd0};
                    phase_next       = PH_DELTA2;
                end
            end
            PH_DELTA2: begin
                delta_accum_next = (delta_accum_reg | {9'd0, b}) + BIAS_EXT2;
                after_delta      = 1'b1;
            end
            PH_LEN1: begin
                if (length_code_reg == CODE_EXT1) begin
                    length_accum_next = {9'd0, b} + BIAS_EXT1;
                    finish_header     = 1'b1;
                end else begin
                    length_accum_next = {1'b0, b, 8'd0};
                    phase_next        = PH_LEN2;
                end
            end
            PH_LEN2: begin
                length_accum_next = (length_accum_reg | {9'd0, b}) + BIAS_EXT2;
                finish_header     = 1'b1;
            end
            PH_VALUE: begin
                res.result_kind = KIND_VALUE;
                res.value_byte  = b;
                res_valid       = 1'b1;
                if (value_remaining_reg <= 17'd1) begin
                    res.last_value       = 1'b1;
                    value_remaining_next = '0;
                    phase_next           = PH_HEADER;
                end else begin
                    value_remaining_next = value_remaining_reg - 17'd1;
                end
            end
            PH_IDLE: begin
                phase_next = PH_IDLE;
            end
            default: begin
                phase_next = PH_IDLE;
            end
        endcase

        // delta done: length extension still pending or header complete
        if (after_delta) begin
            if (length_code_next == CODE_EXT1 || length_code_next == CODE_EXT2) begin
                phase_next = PH_LEN1;
            end else begin
                finish_header = 1'b1;
            end
        end

        if (finish_header) begin
            res.result_kind   = KIND_HEADER;
            res.option_delta  = delta_accum_next;
            res.option_length = length_accum_next;
            res.last_value    = (length_accum_next == '0);
            res_valid         = 1'b1;
            if (length_accum_next != '0) begin
                value_remaining_next = length_accum_next;
                phase_next           = PH_VALUE;
            end else begin
                value_remaining_next = '0;
                phase_next           = PH_HEADER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HEADER;
            delta_code_reg      <= '0;
            length_code_reg     <= '0;
            delta_accum_reg     <= '0;
            length_accum_reg    <= '0;
            value_remaining_reg <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                phase_reg           <= phase_next;
                delta_code_reg      <= delta_code_next;
                length_code_reg     <= length_code_next;
                delta_accum_reg     <= delta_accum_next;
                length_accum_reg    <= length_accum_next;
                value_remaining_reg <= value_remaining_next;
                if (res_valid) begin
                    m_valid_reg <= 1'b1;
                end
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_payload_reg <= res;
        end
    end

endmodule

@@ tb/coap_option_checker.sv @@
module coap_option_checker
    import coap_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    input  logic      s_ready,
    input  coap_in_t  s_payload,
    input  logic      m_valid,
    input  logic      m_ready,
    input  coap_out_t m_payload,
    output int        fail_count,
    output int        results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [2:0] {
        HDR_WAIT,
        DELTA_EXT_A,
        DELTA_EXT_B,
        LEN_EXT_A,
        LEN_EXT_B,
        VALUE_RUN,
        DROP_ALL
    } parse_phase_t;

    parse_phase_t phase;
    logic [3:0]   delta_nib;
    logic [3:0]   length_nib;
    logic [16:0]  delta_sum;
    logic [16:0]  length_sum;
    logic [16:0]  bytes_left;
    coap_out_t    decoded;
    coap_out_t    pending_results [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    function automatic bit emit_header();
        decoded = '0;
        decoded.result_kind   = KIND_HEADER;
        decoded.option_delta  = delta_sum;
        decoded.option_length = length_sum;
        decoded.last_value    = (length_sum == '0);
        if (length_sum != '0) begin
            bytes_left = length_sum;
            phase = VALUE_RUN;
        end else begin
            bytes_left = '0;
            phase = HDR_WAIT;
        end
        return 1'b1;
    endfunction

    // delta finished: length extension bytes may still follow
    function automatic bit delta_finished();
        if (length_nib == CODE_EXT1 || length_nib == CODE_EXT2) begin
            phase = LEN_EXT_A;
            return 1'b0;
        end
        return emit_header();
    endfunction

    function automatic bit decode_byte(input coap_in_t item);
        logic [7:0] b;
        b = item.data_byte;
        decoded = '0;
        if (item.start_of_list) begin
            phase = HDR_WAIT;
        end
        case (phase)
            HDR_WAIT: begin
                if (b == END_MARKER) begin
                    phase = DROP_ALL;
                    decoded.result_kind = KIND_END;
                    return 1'b1;
                end
                delta_nib  = b[7:4];
                length_nib = b[3:0];
                if (delta_nib == CODE_RESERVED || length_nib == CODE_RESERVED) begin
                    phase = DROP_ALL;
                    decoded.result_kind = KIND_ERROR;
                    return 1'b1;
                end
                delta_sum  = 17'(delta_nib);
                length_sum = 17'(length_nib);
                if (delta_nib == CODE_EXT1 || delta_nib == CODE_EXT2) begin
                    phase = DELTA_EXT_A;
                    return 1'b0;
                end
                return delta_finished();
            end
            DELTA_EXT_A: begin
                if (delta_nib == CODE_EXT1) begin
                    delta_sum = 17'(b) + BIAS_EXT1;
                    return delta_finished();
                end
                delta_sum = {1'b0, b, 8'h00};
                phase = DELTA_EXT_B;
                return 1'b0;
            end
            DELTA_EXT_B: begin
                delta_sum = (delta_sum | 17'(b)) + BIAS_EXT2;
                return delta_finished();
            end
            LEN_EXT_A: begin
                if (length_nib == CODE_EXT1) begin
                    length_sum = 17'(b) + BIAS_EXT1;
                    return emit_header();
                end
                length_sum = {1'b0, b, 8'h00};
                phase = LEN_EXT_B;
                return 1'b0;
            end
            LEN_EXT_B: begin
                length_sum = (length_sum | 17'(b)) + BIAS_EXT2;
                return emit_header();
            end
            VALUE_RUN: begin
                decoded.result_kind = KIND_VALUE;
                decoded.value_byte  = b;
                decoded.last_value  = (bytes_left <= 17'd1);
                if (bytes_left <= 17'd1) begin
                    bytes_left = '0;
                    phase = HDR_WAIT;
                end else begin
                    bytes_left = bytes_left - 17'd1;
                end
                return 1'b1;
            end
            default: begin
                phase = DROP_ALL;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        coap_out_t want;
        if (!aresetn) begin
            phase      = HDR_WAIT;
            delta_nib  = '0;
            length_nib = '0;
            delta_sum  = '0;
            length_sum = '0;
            bytes_left = '0;
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result kind %0d",
                                              m_payload.result_kind));
                end else begin
                    want = pending_results.pop_front();
                    if (m_payload.result_kind !== want.result_kind)
                        report_mismatch($sformatf("result_kind got %0d want %0d",
                                                  m_payload.result_kind, want.result_kind));
                    if (m_payload.option_delta !== want.option_delta)
                        report_mismatch($sformatf("option_delta got %0d want %0d",
                                                  m_payload.option_delta, want.option_delta));
                    if (m_payload.option_length !== want.option_length)
                        report_mismatch($sformatf("option_length got %0d want %0d",
                                                  m_payload.option_length, want.option_length));
                    if (m_payload.value_byte !== want.value_byte)
                        report_mismatch($sformatf("value_byte got %h want %h",
                                                  m_payload.value_byte, want.value_byte));
                    if (m_payload.last_value !== want.last_value)
                        report_mismatch($sformatf("last_value got %b want %b",
                                                  m_payload.last_value, want.last_value));
                end
            end
            if (s_valid && s_ready) begin
                if (decode_byte(s_payload)) begin
                    pending_results.push_back(decoded);
                end
            end
        end
        results_pending <= pending_results.size();
    end

endmodule

@@ tb/coap_option_list_parser_top_test.sv @@
module coap_option_list_parser_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import coap_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    localparam int CYCLE_LIMIT  = 200000;

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    coap_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    coap_out_t m_payload;
    int        fail_count;
    int        results_pending;
    int        cycles     = 0;
    int        sent_items = 0;
    bit        quiet      = 1'b0;

    coap_option_list_parser_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    coap_option_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_payload       (s_payload),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_payload       (m_payload),
        .fail_count      (fail_count),
        .results_pending (results_pending)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("coap_option_list_parser_top test failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= quiet || ($urandom_range(0, 99) >= 29);
    end

    task automatic send_byte(input logic [7:0] data, input bit sol, input bit tally);
        while (!quiet && $urandom_range(0, 99) < 29) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= '{data_byte: data, start_of_list: sol};
        do @(posedge aclk); while (!s_ready);
        if (tally) begin
            sent_items++;
        end
    endtask

    // hold the sender until every outstanding result has been taken
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_pending != 0);
    endtask

    task automatic send_option(input bit first);
        logic [7:0]  bytes [$];
        logic [3:0]  d_nib;
        logic [3:0]  l_nib;
        logic [15:0] len_ext;
        int          value_len;
        int          r;
        int          keep;
        r = $urandom_range(0, 9);
        if (r < 7) d_nib = 4'($urandom_range(0, 12));
        else if (r < 9) d_nib = CODE_EXT1;
        else d_nib = CODE_EXT2;
        r = $urandom_range(0, 99);
        len_ext = '0;
        if (r < 75) begin
            l_nib = 4'($urandom_range(0, 12));
            value_len = l_nib;
        end else if (r < 97) begin
            l_nib = CODE_EXT1;
            len_ext = 16'($urandom_range(0, 24));
            value_len = len_ext + 13;
        end else begin
            l_nib = CODE_EXT2;
            len_ext = 16'($urandom_range(0, 40));
            value_len = len_ext + 269;
        end
        bytes.push_back({d_nib, l_nib});
        if (d_nib == CODE_EXT1) begin
            bytes.push_back(8'($urandom_range(0, 255)));
        end else if (d_nib == CODE_EXT2) begin
            bytes.push_back(8'($urandom_range(0, 255)));
            bytes.push_back(8'($urandom_range(0, 255)));
        end
        if (l_nib == CODE_EXT1) begin
            bytes.push_back(len_ext[7:0]);
        end else if (l_nib == CODE_EXT2) begin
            bytes.push_back(len_ext[15:8]);
            bytes.push_back(len_ext[7:0]);
        end
        repeat (value_len) bytes.push_back(8'($urandom_range(0, 255)));
        // now and then cut the option short
        keep = ($urandom_range(0, 19) == 0) ? $urandom_range(1, bytes.size()) : bytes.size();
        for (int i = 0; i < keep; i++) begin
            send_byte(bytes[i], first && i == 0, 1'b1);
        end
    endtask

    initial begin
        int r;
        int n;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // first byte decoded as a header even without start
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h12, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte({CODE_EXT1, 4'd1}, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hAA, 1'b0, 1'b1);
        send_byte({CODE_EXT2, 4'd0}, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b1);
        send_byte({4'd0, CODE_EXT1}, 1'b0, 1'b1);
        send_byte(8'h00, 1'b0, 1'b1);
        send_byte(8'h55, 1'b0, 1'b1);
        // start in the middle of a value
        send_byte(8'hC3, 1'b1, 1'b1);
        send_byte(8'h01, 1'b0, 1'b1);
        send_byte(8'h02, 1'b0, 1'b1);
        send_byte(8'h03, 1'b0, 1'b1);
        send_byte({CODE_EXT2, CODE_EXT2}, 1'b0, 1'b1);
        repeat (4) send_byte(8'hFF, 1'b0, 1'b1);
        send_byte(END_MARKER, 1'b1, 1'b1);
        send_byte(8'h34, 1'b0, 1'b0);
        send_byte({CODE_RESERVED, 4'd0}, 1'b1, 1'b1);
        send_byte({4'd0, CODE_RESERVED}, 1'b1, 1'b1);
        send_byte(END_MARKER, 1'b0, 1'b0);
        drain();

        sent_items = 0;
        while (sent_items < RANDOM_ITEMS) begin
            quiet <= (sent_items >= 300 && sent_items < 500);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
            end else begin
                n = $urandom_range(1, 6);
                for (int i = 0; i < n; i++) begin
                    send_option(i == 0);
                end
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    send_byte(END_MARKER, 1'b0, 1'b1);
                    repeat ($urandom_range(0, 2))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end else if (r < 60) begin
                    if ($urandom_range(0, 1))
                        send_byte({CODE_RESERVED, 4'($urandom_range(0, 15))}, 1'b0, 1'b1);
                    else
                        send_byte({4'($urandom_range(0, 15)), CODE_RESERVED}, 1'b0, 1'b1);
                    repeat ($urandom_range(0, 2))
                        send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                end
            end
            if ($urandom_range(0, 29) == 0) begin
                drain();
            end
        end

        drain();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && results_pending == 0) begin
            $display("coap_option_list_parser_top test passed");
        end else begin
            $display("coap_option_list_parser_top test failed");
        end
        $finish;
    end

endmodule
